// ===== rtl/core/mma_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mma_pkg: shared types and constants
// Command codes, fixed field widths and the control group that walks the
// multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
package mma_pkg;

  // fixed field widths
  localparam int IDX_W   = 3;   // row / column index
  localparam int SIZE_W  = 4;   // matrix_size register
  localparam int ELEM_W  = 16;  // Q1.15 element
  localparam int PROD_W  = 32;  // Q2.30 product
  localparam int ACC_W   = 48;  // Q18.30 accumulator

  // largest size the index fields can address
  localparam int SIZE_LIMIT = 8;

  // accumulator clamp limits
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // input beat commands
  typedef enum logic [1:0] {
    CMD_WRITE_A = 2'd0,
    CMD_WRITE_B = 2'd1,
    CMD_CLEAR_C = 2'd2,
    CMD_RUN     = 2'd3
  } cmd_t;

  // control that travels with one inner-product term
  typedef struct packed {
    logic vld;    // term present
    logic first;  // first term of a C element (k == 0)
    logic last;   // final term of a C element
  } mac_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/matrix_multiply_accumulate_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_unit: square matrix C += A * B
// Element writes fill A and B, a clear zeroes C, a run accumulates A*B into
// C and streams every active C element in row-major order.
//
//   channel  direction  handshake               payload
//   input    in         in_valid / in_stall     command, row, col, value
//   output   out        out_valid / out_stall   out_row, out_col, c_value, last
//   config   in         cfg_write               cfg_data (matrix_size)
//
// Write and clear beats are taken only while the unit is idle. A run of size n
// holds in_stall high until its last C beat is taken, output stalls included:
// each C element streams its n terms through the one shared multiplier/accumulator,
// then waits for the pipeline to drain and for its output beat.
// Reset clears C (per-entry valid bits) and sets matrix_size to 8; A and B
// hold garbage until written. A stalled output beat freezes the sequencer.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate_unit
  import mma_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // configuration
  input  wire logic                     cfg_write,
  input  wire logic [SIZE_W-1:0]        cfg_data,
  // input beats
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               command,
  input  wire logic [IDX_W-1:0]         row,
  input  wire logic [IDX_W-1:0]         col,
  input  wire logic signed [ELEM_W-1:0] value,
  // output beats
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [IDX_W-1:0]              out_row,
  output logic [IDX_W-1:0]              out_col,
  output logic signed [ACC_W-1:0]       c_value,
  output logic                          last
);

  localparam int DIM   = (MAX_DIM < SIZE_LIMIT) ? MAX_DIM : SIZE_LIMIT;
  localparam int DEPTH = DIM * DIM;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t                   state;
  logic [SIZE_W-1:0]        matrix_size;
  logic [SIZE_W-1:0]        n_act;
  logic [IDX_W-1:0]         n_m1;
  logic [IDX_W-1:0]         i_idx;
  logic [IDX_W-1:0]         j_idx;
  logic [IDX_W-1:0]         k_idx;
  logic                     in_acc;
  logic                     out_acc;
  cmd_t                     cmd;
  logic                     in_range;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            a_addr;
  logic [AW-1:0]            b_addr;
  logic [AW-1:0]            c_addr;
  mac_ctl_t                 ctl0;
  mac_ctl_t                 ctl1;
  logic signed [ELEM_W-1:0] a_q;
  logic signed [ELEM_W-1:0] b_q;
  logic signed [ACC_W-1:0]  c_mem [DEPTH];
  logic [DEPTH-1:0]         c_valid;
  logic signed [ACC_W-1:0]  c_q;
  logic                     c_hit;
  logic signed [ACC_W-1:0]  c_base;
  logic signed [ACC_W-1:0]  mac_acc;
  logic                     mac_done;
  logic                     elem_last;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign cmd      = cmd_t'(command);
  assign in_stall = (state != S_IDLE);

  // size register
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_W'(SIZE_LIMIT);
    end else if (cfg_write) begin
      matrix_size <= cfg_data;
    end
  end

  // active size: zero reads as one, clipped to the store dimension
  always_comb begin
    if (matrix_size == '0) begin
      n_act = SIZE_W'(1);
    end else if (matrix_size > SIZE_W'(DIM)) begin
      n_act = SIZE_W'(DIM);
    end else begin
      n_act = matrix_size;
    end
  end

  // element addressing
  assign in_range  = ({1'b0, row} < SIZE_W'(DIM)) && ({1'b0, col} < SIZE_W'(DIM));
  assign wr_addr   = AW'(row) * AW'(DIM) + AW'(col);
  assign a_addr    = AW'(i_idx) * AW'(DIM) + AW'(k_idx);
  assign b_addr    = AW'(k_idx) * AW'(DIM) + AW'(j_idx);
  assign c_addr    = AW'(i_idx) * AW'(DIM) + AW'(j_idx);
  assign elem_last = (i_idx == n_m1) && (j_idx == n_m1);

  // term issue
  always_comb begin
    ctl0.vld   = (state == S_RUN);
    ctl0.first = (k_idx == '0);
    ctl0.last  = (k_idx == n_m1);
  end

  // operand stores
  mma_ab_mem #(.DEPTH(DEPTH), .AW(AW)) u_a_mem (
    .clk     (clk),
    .wr_en   (in_acc && (cmd == CMD_WRITE_A) && in_range),
    .wr_addr (wr_addr),
    .wr_data (value),
    .rd_addr (a_addr),
    .rd_data (a_q)
  );

  mma_ab_mem #(.DEPTH(DEPTH), .AW(AW)) u_b_mem (
    .clk     (clk),
    .wr_en   (in_acc && (cmd == CMD_WRITE_B) && in_range),
    .wr_addr (wr_addr),
    .wr_data (value),
    .rd_addr (b_addr),
    .rd_data (b_q)
  );

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else begin
      ctl1 <= ctl0;
    end
  end

  // C store: read on the first term, write back when the element is done
  always_ff @(posedge clk) begin
    if (ctl0.vld && ctl0.first) begin
      c_q   <= c_mem[c_addr];
      c_hit <= c_valid[c_addr];
    end
    if ((state == S_DRAIN) && mac_done) begin
      c_mem[c_addr] <= mac_acc;
    end
  end

  // C valid bits; clear drops them all at once
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= '0;
    end else if (in_acc && (cmd == CMD_CLEAR_C)) begin
      c_valid <= '0;
    end else if ((state == S_DRAIN) && mac_done) begin
      c_valid[c_addr] <= 1'b1;
    end
  end

  assign c_base = c_hit ? c_q : '0;

  mma_mac_unit u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl1),
    .a_op   (a_q),
    .b_op   (b_q),
    .c_base (c_base),
    .acc    (mac_acc),
    .done   (mac_done)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      last      <= 1'b0;
      i_idx     <= '0;
      j_idx     <= '0;
      k_idx     <= '0;
      n_m1      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc && (cmd == CMD_RUN)) begin
            i_idx <= '0;
            j_idx <= '0;
            k_idx <= '0;
            n_m1  <= IDX_W'(n_act - SIZE_W'(1));
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (k_idx == n_m1) begin
            k_idx <= '0;
            state <= S_DRAIN;
          end else begin
            k_idx <= k_idx + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          if (mac_done) begin
            out_valid <= 1'b1;
            last      <= elem_last;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            out_valid <= 1'b0;
            if (last) begin
              state <= S_IDLE;
            end else begin
              if (j_idx == n_m1) begin
                j_idx <= '0;
                i_idx <= i_idx + IDX_W'(1);
              end else begin
                j_idx <= j_idx + IDX_W'(1);
              end
              state <= S_RUN;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out_row = i_idx;
  assign out_col = j_idx;
  assign c_value = mac_acc;

`ifndef SYNTH
  // input is never taken while a result is pending
  a_no_input_with_output: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input ready while an output beat is pending");

  // the accumulator only finishes while the sequencer waits for it
  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == S_DRAIN))
    else $error("accumulate finished outside drain");

  // every output beat follows a finished accumulation
  a_out_after_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(mac_done))
    else $error("output beat without a finished element");

  // the final beat sits on the diagonal corner
  a_last_on_corner: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> ((out_row == n_m1) && (out_col == n_m1)))
    else $error("last flag away from the final element");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/mma_ab_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mma_ab_mem: operand element store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mma_ab_mem
  import mma_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic signed [ELEM_W-1:0] wr_data,
  input  wire logic [AW-1:0]            rd_addr,
  output logic signed [ELEM_W-1:0]      rd_data
);

  logic signed [ELEM_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/mma_mac_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mma_mac_unit: shared multiply and saturating accumulate
// Stage 1 registers the Q2.30 product, stage 2 adds it into the Q18.30
// accumulator with clamping after every addition.
// ----------------------------------------------------------------------------
module mma_mac_unit
  import mma_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire mac_ctl_t                 ctl,
  input  wire logic signed [ELEM_W-1:0] a_op,
  input  wire logic signed [ELEM_W-1:0] b_op,
  input  wire logic signed [ACC_W-1:0]  c_base,
  output logic signed [ACC_W-1:0]       acc,
  output logic                          done
);

  mac_ctl_t                  ctl_p;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   base;
  logic signed [ACC_W:0]     sum;
  logic signed [ACC_W-1:0]   acc_next;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_p <= '0;
    end else begin
      ctl_p <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a_op * b_op);
  end

  // saturating add; first term starts from the stored C element
  always_comb begin
    base = ctl_p.first ? c_base : acc;
    sum  = {base[ACC_W-1], base} + {{(ACC_W + 1 - PROD_W){prod[PROD_W-1]}}, prod};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_next = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_next = sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_p.vld) begin
      acc <= acc_next;
    end
  end

  // element finished
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_p.vld && ctl_p.last;
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for matrix_multiply_accumulate_unit
// A directed script covers element extremes, every command, size clamping and
// accumulation across runs. Random write/clear/run sequences follow at several
// sizes, each closing with a run. Each emitted C beat is checked against an
// in-bench model of C += A*B.
// ----------------------------------------------------------------------------
module tb_top;
  import mma_pkg::*;

  localparam int DIM           = 8;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [3:0] SEG_SIZES [6] = '{4'd15, 4'd3, 4'd1, 4'd0, 4'd8, 4'd2};

  typedef enum logic {STEP_BEAT, STEP_SIZE} step_kind_t;

  typedef struct packed {
    step_kind_t               kind;
    cmd_t                     cmd;
    logic [IDX_W-1:0]         r;
    logic [IDX_W-1:0]         c;
    logic signed [ELEM_W-1:0] v;
    logic [SIZE_W-1:0]        size;
    logic                     fixed;   // c_due is the known single result
    logic signed [ACC_W-1:0]  c_due;
  } script_row_t;

  typedef struct {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [ACC_W-1:0] value;
    logic                    last;
  } c_elem_t;

  // directed script
  localparam script_row_t SCRIPT [26] = '{
    '{STEP_SIZE, CMD_WRITE_A, 3'd0, 3'd0, 16'sd0,     4'd1, 1'b0, 48'sd0},
    '{STEP_BEAT, CMD_WRITE_A, 3'd0, 3'd0, 16'sh8000,  4'd0, 1'b0, 48'sd0},
    '{STEP_BEAT, CMD_WRITE_B, 3'd0, 3'd0, 16'sh8000,  4'd0, 1'b0, 48'sd0},
    '{STEP_BEAT, CMD_RUN,     3'd0, 3'd0, 16'sd0,     4'd0, 1'b1, 48'sh0000_4000_0000},
    '{STEP_BEAT, CMD_RUN,     3'd0, 3'd0, 16'sd0,     4'd0, 1'b1, 48'sh0000_8000_0000},
    '{STEP_BEAT, CMD_CLEAR_C, 3'd7, 3'd7, 16'shFFFF,  4'd0, 1'b0, 48'sd0},
    '{STEP_BEAT, CMD_WRITE_B, 3'd0, 3'd0, 16'sh7FFF,  4'd0, 1'b0, 48'sd0},
    '{STEP_BEAT, CMD_RUN,     3'd7, 3'd7, 16'shFFFF,  4'd0, 1'b1, 48'shFFFF_C000_8000},
    '{STEP_SIZE, CMD_WRITE_A, 3'd0, 3'd0, 16'sd0,     4'd0, 1'b0, 48'sd0},
    '{STEP_BEAT, CMD_WRITE_A, 3'd0, 3'd0, 16'sh7FFF,  4'd0, 1'b0, 48'sd0},
    '{STEP_BEAT, CMD_RUN,     3'd0, 3'd0, 16'sd0,     4'd0, 1'b1, 48'shFFFF_FFFF_8001},
    '{STEP_BEAT, CMD_CLEAR_C, 3'd0, 3'd0, 16'sd0,     4'd0, 1'b0, 48'sd0},
    '{STEP_BEAT, CMD_WRITE_A, 3'd0, 3'd0, 16'sd0,     4'd0, 1'b0, 48'sd0},
    '{STEP_BEAT, CMD_RUN,     3'd0, 3'd0, 16'sd0,     4'd0, 1'b1, 48'sd0},
    '{STEP_BEAT, CMD_WRITE_A, 3'd7, 3'd7, 16'sd12345, 4'd0, 1'b0, 48'sd0},
    '{STEP_BEAT, CMD_WRITE_B, 3'd7, 3'd7, 16'shFFFF,  4'd0, 1'b0, 48'sd0},
    '{STEP_SIZE, CMD_WRITE_A, 3'd0, 3'd0, 16'sd0,     4'd2, 1'b0, 48'sd0},
    '{STEP_BEAT, CMD_WRITE_A, 3'd0, 3'd1, 16'sh8000,  4'd0, 1'b0, 48'sd0},
    '{STEP_BEAT, CMD_WRITE_A, 3'd1, 3'd0, 16'sh7FFF,  4'd0, 1'b0, 48'sd0},
    '{STEP_BEAT, CMD_WRITE_A, 3'd1, 3'd1, 16'sd1,     4'd0, 1'b0, 48'sd0},
    '{STEP_BEAT, CMD_WRITE_B, 3'd0, 3'd1, 16'sd2,     4'd0, 1'b0, 48'sd0},
    '{STEP_BEAT, CMD_WRITE_B, 3'd1, 3'd0, 16'shFFFE,  4'd0, 1'b0, 48'sd0},
    '{STEP_BEAT, CMD_WRITE_B, 3'd1, 3'd1, 16'sh7FFF,  4'd0, 1'b0, 48'sd0},
    '{STEP_BEAT, CMD_RUN,     3'd0, 3'd0, 16'sd0,     4'd0, 1'b0, 48'sd0},
    '{STEP_BEAT, CMD_RUN,     3'd0, 3'd0, 16'sd0,     4'd0, 1'b0, 48'sd0},
    '{STEP_BEAT, CMD_CLEAR_C, 3'd0, 3'd0, 16'sd0,     4'd0, 1'b0, 48'sd0}
  };

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [SIZE_W-1:0]        cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  cmd_t                     command   = CMD_WRITE_A;
  logic [IDX_W-1:0]         row       = '0;
  logic [IDX_W-1:0]         col       = '0;
  logic signed [ELEM_W-1:0] value     = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [ACC_W-1:0]  c_value;
  logic                     last;

  // model state
  logic signed [ELEM_W-1:0] mat_a [DIM*DIM];
  logic signed [ELEM_W-1:0] mat_b [DIM*DIM];
  logic signed [ACC_W-1:0]  mat_c [DIM*DIM];
  bit                       a_set [DIM*DIM];
  bit                       b_set [DIM*DIM];
  logic [SIZE_W-1:0]        size_reg = 4'd8;

  c_elem_t c_elems_due [$];
  c_elem_t want_elem;
  int      mismatches = 0;
  int      gap_pct    = 0;
  int      stall_pct  = 0;

  matrix_multiply_accumulate_unit #(.MAX_DIM(DIM)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .row       (row),
    .col       (col),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (out_row),
    .out_col   (out_col),
    .c_value   (c_value),
    .last      (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    foreach (mat_c[idx]) mat_c[idx] = '0;
  end

  // size 0 acts as 1; anything above the index range or the build is clamped
  function automatic int eff_size(input logic [SIZE_W-1:0] s);
    int n;
    n = s;
    if (n == 0) n = 1;
    if (n > SIZE_LIMIT) n = SIZE_LIMIT;
    if (n > DIM) n = DIM;
    return n;
  endfunction

  function automatic logic signed [ACC_W-1:0] clamp_sum(
    input logic signed [ACC_W-1:0] acc, input logic signed [PROD_W-1:0] term);
    longint total;
    total = longint'(acc) + longint'(term);
    if (total > longint'(ACC_MAX)) return ACC_MAX;
    if (total < longint'(ACC_MIN)) return ACC_MIN;
    return 48'(total);
  endfunction

  function automatic logic signed [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sd0;
      3: return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // track one accepted input beat; runs append their C stream to the queue when publish is set
  task automatic predict_c_stream(input cmd_t cmd, input logic [IDX_W-1:0] r,
                                  input logic [IDX_W-1:0] c,
                                  input logic signed [ELEM_W-1:0] v, input bit publish);
    int n, i, j, k;
    logic signed [PROD_W-1:0] prod;
    case (cmd)
      CMD_WRITE_A: begin
        if (r < DIM && c < DIM) begin
          mat_a[r*DIM+c] = v;
          a_set[r*DIM+c] = 1'b1;
        end
      end
      CMD_WRITE_B: begin
        if (r < DIM && c < DIM) begin
          mat_b[r*DIM+c] = v;
          b_set[r*DIM+c] = 1'b1;
        end
      end
      CMD_CLEAR_C: begin
        foreach (mat_c[idx]) mat_c[idx] = '0;
      end
      CMD_RUN: begin
        n = eff_size(size_reg);
        // terms go in by increasing k, clamping after every add
        for (i = 0; i < n; i++)
          for (k = 0; k < n; k++)
            for (j = 0; j < n; j++) begin
              prod = mat_a[i*DIM+k] * mat_b[k*DIM+j];
              mat_c[i*DIM+j] = clamp_sum(mat_c[i*DIM+j], prod);
            end
        if (publish)
          for (i = 0; i < n; i++)
            for (j = 0; j < n; j++)
              c_elems_due.push_back('{3'(i), 3'(j), mat_c[i*DIM+j],
                                      (i == n-1) && (j == n-1)});
      end
    endcase
  endtask

  // present one input beat, with random gaps ahead of it
  task automatic send_beat(input cmd_t cmd, input logic [IDX_W-1:0] r,
                           input logic [IDX_W-1:0] c, input logic signed [ELEM_W-1:0] v,
                           input bit fixed = 1'b0,
                           input logic signed [ACC_W-1:0] c_fixed = '0);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    row      <= r;
    col      <= c;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_c_stream(cmd, r, c, v, !fixed);
    if (fixed) c_elems_due.push_back('{3'd0, 3'd0, c_fixed, 1'b1});
  endtask

  // hold the input off until every C beat is back and the run has wound down
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (c_elems_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input logic [SIZE_W-1:0] s);
    wait_for_results();
    cfg_write <= 1'b1;
    cfg_data  <= s;
    @(posedge clk);
    cfg_write <= 1'b0;
    size_reg = s;
  endtask

  // a run may only touch A and B entries that hold data
  task automatic prime_operands();
    int n, r, c;
    n = eff_size(size_reg);
    for (r = 0; r < n; r++)
      for (c = 0; c < n; c++) begin
        if (!a_set[r*DIM+c]) send_beat(CMD_WRITE_A, 3'(r), 3'(c), rand_elem());
        if (!b_set[r*DIM+c]) send_beat(CMD_WRITE_B, 3'(r), 3'(c), rand_elem());
      end
  endtask

  task automatic check_field(input string tag, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d", tag, want, got);
    end
  endtask

  // output side: check accepted C beats, stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (c_elems_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("C beat with none pending: row %0d col %0d value %0d",
                     out_row, out_col, c_value);
        end else begin
          want_elem = c_elems_due.pop_front();
          check_field("out_row", want_elem.row, out_row);
          check_field("out_col", want_elem.col, out_col);
          check_field("c_value", want_elem.value, c_value);
          check_field("last", want_elem.last, last);
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    int seg, pick;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed script
    gap_pct   = 20;
    stall_pct = 49;
    foreach (SCRIPT[idx]) begin
      if (SCRIPT[idx].kind == STEP_SIZE) begin
        set_size(SCRIPT[idx].size);
      end else begin
        send_beat(SCRIPT[idx].cmd, SCRIPT[idx].r, SCRIPT[idx].c, SCRIPT[idx].v,
                  SCRIPT[idx].fixed, SCRIPT[idx].c_due);
      end
    end

    // random write/clear/run sequences, one size per segment
    for (seg = 0; seg < 8; seg++) begin
      if (seg == 3) begin
        gap_pct   = 49;
        stall_pct = 20;
      end
      if (seg == 6) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      set_size(seg < 6 ? SEG_SIZES[seg] : 4'($urandom_range(0, 15)));
      repeat (6) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          send_beat(CMD_WRITE_A, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                    rand_elem());
        end else if (pick < 80) begin
          send_beat(CMD_WRITE_B, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                    rand_elem());
        end else if (pick < 86) begin
          send_beat(CMD_CLEAR_C, 3'($urandom), 3'($urandom), 16'($urandom));
        end else begin
          prime_operands();
          send_beat(CMD_RUN, 3'($urandom), 3'($urandom), 16'($urandom));
        end
        if ($urandom_range(0, 24) == 0) wait_for_results();
      end
      // every segment ends on a run
      prime_operands();
      send_beat(CMD_RUN, 3'($urandom), 3'($urandom), 16'($urandom));
    end

    wait_for_results();
    if (mismatches == 0) begin
      $display("[matrix_multiply_accumulate_unit] OK");
    end else begin
      $display("[matrix_multiply_accumulate_unit] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100_000_000;
    $display("[matrix_multiply_accumulate_unit] ERROR");
    $finish;
  end

endmodule
